// File: rtl/core/tccw_pkg.sv
// Package for the text console cell writer: geometry, character codes,
// request/result structs and sequencer states. No dependencies.
package tccw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int CX_W      = COL_W + 1;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int IDX_W     = 11;
    localparam int WIDE_W    = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int FILL_BASE = (ROWS - 1) * COLUMNS;
    localparam int CELL_W    = 16;

    localparam logic [7:0] CODE_TAB      = 8'd9;
    localparam logic [7:0] CODE_NEWLINE  = 8'd10;
    localparam logic [7:0] CODE_SPACE    = 8'd32;
    localparam logic [7:0] ATTR_AT_RESET = 8'h1f;
    localparam logic [2:0] TAB_MASK      = 3'd7;

    typedef struct packed {
        logic              cell_written;
        logic [IDX_W-1:0]  cell_index;
        logic [7:0]        glyph;
        logic [7:0]        glyph_attr;
        logic [IDX_W-1:0]  cursor_position;
        logic              scrolled;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } cell_wr_t;

    typedef struct packed {
        logic idle;
        logic scroll_done;
    } sweep_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } sweep_state_t;

    function automatic logic [IDX_W-1:0] fit_idx(input logic [ADDR_W-1:0] a);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(a);
        return w[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/tccw_char_if.sv
// Character request channel: valid/ready plus the character byte.
// Depends on nothing.
interface tccw_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

// File: rtl/core/tccw_result_if.sv
// Result channel: valid/ready plus the written cell, cursor and scroll flag.
// Depends on tccw_pkg for the index width.
interface tccw_result_if;
    logic                        valid;
    logic                        ready;
    logic                        cell_written;
    logic [tccw_pkg::IDX_W-1:0]  cell_index;
    logic [7:0]                  glyph;
    logic [7:0]                  glyph_attr;
    logic [tccw_pkg::IDX_W-1:0]  cursor_position;
    logic                        scrolled;

    modport source (output valid, output cell_written, output cell_index, output glyph,
                    output glyph_attr, output cursor_position, output scrolled,
                    input ready);
    modport sink (input valid, input cell_written, input cell_index, input glyph,
                  input glyph_attr, input cursor_position, input scrolled,
                  output ready);
endinterface

// File: rtl/core/tccw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/tccw_cursor.sv
// Cursor tracker: column, row and row base; builds the result and the cell write.
// Depends on tccw_pkg.
module tccw_cursor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         char_code,
    input  logic [7:0]         attr,
    output tccw_pkg::res_t     res,
    output tccw_pkg::cell_wr_t cwr
);
    import tccw_pkg::*;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              is_tab, is_nl, is_glyph, col_wrap, wrap, row_over;
    logic [CX_W-1:0]   col_ext, col_adv;
    logic [ADDR_W-1:0] cur_idx, new_idx;

    always_comb
    begin
        is_tab   = (char_code == CODE_TAB);
        is_nl    = (char_code == CODE_NEWLINE);
        is_glyph = !is_tab && !is_nl;
        col_ext  = CX_W'(col_reg);
        col_adv  = is_tab ? ((col_ext | CX_W'(TAB_MASK)) + CX_W'(1)) : (col_ext + CX_W'(1));
        col_wrap = (col_adv >= CX_W'(COLUMNS));
        wrap     = is_nl || col_wrap;
        row_over = wrap && (row_reg == ROW_W'(ROWS - 1));
        if (is_nl)
        begin
            col_next = '0;
        end
        else if (col_wrap)
        begin
            col_next = COL_W'(col_adv - CX_W'(COLUMNS));
        end
        else
        begin
            col_next = COL_W'(col_adv);
        end
        row_next  = (wrap && !row_over) ? (row_reg + ROW_W'(1)) : row_reg;
        base_next = (wrap && !row_over) ? (base_reg + ADDR_W'(COLUMNS)) : base_reg;
        cur_idx   = base_reg + ADDR_W'(col_reg);
        new_idx   = base_next + ADDR_W'(col_next);
    end

    always_comb
    begin
        res.cell_written    = is_glyph;
        res.cell_index      = is_glyph ? fit_idx(cur_idx) : '0;
        res.glyph           = is_glyph ? char_code : '0;
        res.glyph_attr      = is_glyph ? attr : '0;
        res.cursor_position = fit_idx(new_idx);
        res.scrolled        = row_over;
        cwr.en              = accept && is_glyph;
        cwr.addr            = cur_idx;
        cwr.data            = {attr, char_code};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end
endmodule

// File: rtl/core/tccw_sweep.sv
// Cell store sequencer: reset clearing pass, character writes and the scroll sweep;
// the clearing pass and the sweep share one address counter. Depends on tccw_pkg and tccw_ram.
module tccw_sweep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tccw_pkg::cell_wr_t    cwr,
    input  logic                  start,
    input  logic [7:0]            attr,
    output tccw_pkg::sweep_stat_t stat
);
    import tccw_pkg::*;

    sweep_state_t      state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] cnt_inc;
    logic              last;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    assign cnt_inc = cnt_reg + ADDR_W'(1);
    assign last    = (cnt_reg == ADDR_W'(CELLS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = last ? '0 : cnt_inc;
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_COPY;
                    cnt_next   = ADDR_W'(COLUMNS);
                end
            end
            ST_COPY:
            begin
                cnt_next = cnt_inc;
                if (last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FILL;
                cnt_next   = ADDR_W'(FILL_BASE);
            end
            ST_FILL:
            begin
                cnt_next = cnt_inc;
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we           = 1'b0;
        ram_waddr        = cnt_reg;
        ram_wdata        = {ATTR_AT_RESET, CODE_SPACE};
        ram_raddr        = cnt_reg;
        stat.idle        = 1'b0;
        stat.scroll_done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                ram_we    = cwr.en;
                ram_waddr = cwr.addr;
                ram_wdata = cwr.data;
            end
            ST_COPY, ST_DRAIN:
            begin
                ram_we    = pend_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = ram_rdata;
            end
            ST_FILL:
            begin
                ram_we           = 1'b1;
                ram_wdata        = {attr, CODE_SPACE};
                stat.scroll_done = last;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= (state_reg == ST_COPY);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cnt_reg - ADDR_W'(COLUMNS);
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

// File: rtl/core/text_console_cell_writer_core.sv
// Text console cell writer, top level: handshake, attribute register, result register.
// Depends on tccw_pkg, tccw_char_if, tccw_result_if, tccw_cursor and tccw_sweep.
//
// Each character request moves the cursor over a COLUMNS x ROWS cell store and a glyph
// writes its cell; a request that does not scroll yields one result the next cycle,
// and with the result side taking every cycle, tab, newline and glyph requests are
// accepted one per cycle. A request that scrolls starts a sweep of the store through
// its single RAM write port: a copy of every row but the top one up by one row, a
// drain state and a blank fill of the bottom row, after which its result appears
// and requests are taken again. After reset a clearing pass writes spaces with
// attribute 0x1f to every cell; no request is accepted meanwhile, attribute writes are.
module text_console_cell_writer_core (
    input  logic       clk,
    input  logic       rst_n,
    tccw_char_if.sink  chars,
    tccw_result_if.source results,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import tccw_pkg::*;

    logic [7:0]  attr_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    res_t        res;
    cell_wr_t    cwr;
    sweep_stat_t stat;
    logic        accept;

    assign chars.ready = stat.idle && (!out_valid_reg || results.ready);
    assign accept      = chars.valid && chars.ready;

    tccw_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (chars.char_code),
        .attr      (attr_reg),
        .res       (res),
        .cwr       (cwr)
    );

    tccw_sweep u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .cwr   (cwr),
        .start (accept && res.scrolled),
        .attr  (attr_reg),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_AT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (accept)
            begin
                out_valid_reg <= !res.scrolled;
            end
            else if (stat.scroll_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg <= res;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.cell_written    = out_res_reg.cell_written;
    assign results.cell_index      = out_res_reg.cell_index;
    assign results.glyph           = out_res_reg.glyph;
    assign results.glyph_attr      = out_res_reg.glyph_attr;
    assign results.cursor_position = out_res_reg.cursor_position;
    assign results.scrolled        = out_res_reg.scrolled;

    a_scroll_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.scrolled |=> !stat.idle)
        else $error("scroll request did not start the store sweep");

    a_no_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.idle |-> !chars.ready)
        else $error("request taken while the store sweep runs");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.idle |-> !results.valid)
        else $error("result shown before the store sweep finished");
endmodule
